>>> src/tfcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture format convert and scale package
// Item types, register indexes, format codes and the pixel decode and encode
// functions shared by the front and back parts.
// ----------------------------------------------------------------------------
package tfcs_pkg;

	// Pixel format codes.
	localparam logic [3:0] FMT_RGBA = 4'd0;
	localparam logic [3:0] FMT_BGRA = 4'd1;
	localparam logic [3:0] FMT_RGBX = 4'd2;
	localparam logic [3:0] FMT_BGRX = 4'd3;
	localparam logic [3:0] FMT_RGB  = 4'd4;
	localparam logic [3:0] FMT_BGR  = 4'd5;
	localparam logic [3:0] FMT_4444 = 4'd6;
	localparam logic [3:0] FMT_5551 = 4'd7;
	localparam logic [3:0] FMT_565  = 4'd8;
	localparam logic [3:0] FMT_A    = 4'd9;
	localparam logic [3:0] FMT_A4   = 4'd10;
	localparam logic [3:0] FMT_G    = 4'd11;
	localparam logic [3:0] FMT_GA   = 4'd12;

	// Register indexes (word address on the configuration port).
	localparam logic [2:0] REG_SRC_FMT = 3'd0;
	localparam logic [2:0] REG_DST_FMT = 3'd1;
	localparam logic [2:0] REG_SRC_W   = 3'd2;
	localparam logic [2:0] REG_SRC_H   = 3'd3;
	localparam logic [2:0] REG_DST_W   = 3'd4;
	localparam logic [2:0] REG_DST_H   = 3'd5;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_EMIT = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] source_pixel;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] dest_pixel;
		logic        row_end;
		logic        frame_end;
	} res_item_t;

	// Entry of the queue between the front and back parts.
	typedef struct packed {
		logic        emit;
		logic [31:0] word;
	} mid_entry_t;

	// Configuration as seen by the back part.
	typedef struct packed {
		logic [3:0] dst_fmt;
		logic [8:0] src_w;
		logic [8:0] src_h;
		logic [8:0] dst_w;
		logic [8:0] dst_h;
	} cfg_t;

	function automatic logic [31:0] swap_rb(input logic [31:0] p);
		return {p[31:24], p[7:0], p[15:8], p[23:16]};
	endfunction

	function automatic logic [7:0] widen4(input logic [3:0] v);
		return {v, v};
	endfunction

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// Decode a packed source pixel into canonical RGBA (R in the low byte).
	function automatic logic [31:0] decode(input logic [31:0] p, input logic [3:0] fmt);
		logic [31:0] r;
		case (fmt)
			FMT_RGBA: r = p;
			FMT_BGRA: r = swap_rb(p);
			FMT_RGBX: r = {8'hFF, p[23:0]};
			FMT_BGRX: r = {8'hFF, p[7:0], p[15:8], p[23:16]};
			FMT_RGB:  r = {8'hFF, p[23:0]};
			FMT_BGR:  r = {8'hFF, p[7:0], p[15:8], p[23:16]};
			FMT_4444: r = {widen4(p[15:12]), widen4(p[11:8]), widen4(p[7:4]),
				widen4(p[3:0])};
			FMT_5551: r = {{8{p[15]}}, widen5(p[14:10]), widen5(p[9:5]), widen5(p[4:0])};
			FMT_565:  r = {8'hFF, widen5(p[15:11]), widen6(p[10:5]), widen5(p[4:0])};
			FMT_A:    r = {p[7:0], 24'hFFFFFF};
			FMT_A4:   r = {widen4(p[3:0]), 24'hFFFFFF};
			FMT_G:    r = {8'hFF, p[7:0], p[7:0], p[7:0]};
			FMT_GA:   r = {p[15:8], p[7:0], p[7:0], p[7:0]};
			default:  r = 32'd0;
		endcase
		return r;
	endfunction

	// Encode canonical RGBA into a packed destination pixel.
	function automatic logic [31:0] encode(input logic [31:0] p, input logic [3:0] fmt);
		logic [31:0] r;
		case (fmt)
			FMT_RGBA: r = p;
			FMT_BGRA: r = swap_rb(p);
			FMT_RGBX: r = p;
			FMT_BGRX: r = swap_rb(p);
			FMT_RGB:  r = {8'd0, p[23:0]};
			FMT_BGR:  r = {8'd0, p[7:0], p[15:8], p[23:16]};
			FMT_4444: r = {16'd0, p[31:28], p[23:20], p[15:12], p[7:4]};
			FMT_5551: r = {16'd0, p[31], p[23:19], p[15:11], p[7:3]};
			FMT_565:  r = {16'd0, p[23:19], p[15:10], p[7:3]};
			FMT_A:    r = {24'd0, p[31:24]};
			FMT_A4:   r = {28'd0, p[31:28]};
			FMT_G:    r = {24'd0, p[15:8]};
			FMT_GA:   r = {16'd0, p[31:16]};
			default:  r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/texture_format_convert_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Texture format convert and scale
// Nearest-neighbor scaler with pixel format conversion. Loads fill a frame
// store in raster order; emits read the nearest source pixel and encode it.
// A load passes through a multiply and a write state in the back part; an emit
// waits on the bit-serial column and row dividers.
// One transaction is carried out at a time; two-entry queues on each side.
// Asynchronous active-low reset clears counters, queues and configuration registers;
// the frame store and the datapath registers are not cleared.
// ----------------------------------------------------------------------------
module texture_format_convert_scale #(
	parameter int MAX_DIM = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [4:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 push,
	output logic                 full,
	input  tfcs_pkg::cmd_item_t  command_item,
	output logic                 empty,
	input  logic                 pop,
	output tfcs_pkg::res_item_t  result_item
);
	logic [3:0]           src_fmt_q;
	logic [3:0]           dst_fmt_q;
	logic [8:0]           src_w_q;
	logic [8:0]           src_h_q;
	logic [8:0]           dst_w_q;
	logic [8:0]           dst_h_q;
	logic                 cfg_wr;
	tfcs_pkg::cfg_t       cfg;
	logic                 mid_push;
	logic                 mid_pop;
	logic                 mid_full;
	logic                 mid_empty;
	tfcs_pkg::mid_entry_t mid_in;
	tfcs_pkg::mid_entry_t mid_out;
	logic                 out_push;
	logic                 out_full;
	tfcs_pkg::res_item_t  out_item;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt_q <= tfcs_pkg::FMT_RGBA;
			dst_fmt_q <= tfcs_pkg::FMT_RGBA;
			src_w_q   <= 9'd256;
			src_h_q   <= 9'd256;
			dst_w_q   <= 9'd256;
			dst_h_q   <= 9'd256;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				tfcs_pkg::REG_SRC_FMT: src_fmt_q <= pwdata[3:0];
				tfcs_pkg::REG_DST_FMT: dst_fmt_q <= pwdata[3:0];
				tfcs_pkg::REG_SRC_W:   src_w_q   <= pwdata[8:0];
				tfcs_pkg::REG_SRC_H:   src_h_q   <= pwdata[8:0];
				tfcs_pkg::REG_DST_W:   dst_w_q   <= pwdata[8:0];
				tfcs_pkg::REG_DST_H:   dst_h_q   <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (paddr[4:2])
			tfcs_pkg::REG_SRC_FMT: prdata = {28'd0, src_fmt_q};
			tfcs_pkg::REG_DST_FMT: prdata = {28'd0, dst_fmt_q};
			tfcs_pkg::REG_SRC_W:   prdata = {23'd0, src_w_q};
			tfcs_pkg::REG_SRC_H:   prdata = {23'd0, src_h_q};
			tfcs_pkg::REG_DST_W:   prdata = {23'd0, dst_w_q};
			tfcs_pkg::REG_DST_H:   prdata = {23'd0, dst_h_q};
			default:               prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.dst_fmt = dst_fmt_q;
		cfg.src_w   = src_w_q;
		cfg.src_h   = src_h_q;
		cfg.dst_w   = dst_w_q;
		cfg.dst_h   = dst_h_q;
	end

	tfcs_front u_front (
		.push         (push),
		.command_item (command_item),
		.src_fmt      (src_fmt_q),
		.mid_full     (mid_full),
		.full         (full),
		.mid_push     (mid_push),
		.mid_entry    (mid_in)
	);

	tfcs_fifo #(.W($bits(tfcs_pkg::mid_entry_t)), .DEPTH(2)) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_in),
		.pop    (mid_pop),
		.rdata  (mid_out),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	tfcs_back #(.MAX_DIM(MAX_DIM)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_entry (mid_out),
		.mid_pop   (mid_pop),
		.out_full  (out_full),
		.out_push  (out_push),
		.out_item  (out_item)
	);

	tfcs_fifo #(.W($bits(tfcs_pkg::res_item_t)), .DEPTH(2)) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_item),
		.pop    (pop),
		.rdata  (result_item),
		.full   (out_full),
		.empty  (empty)
	);

endmodule

>>> src/tfcs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small synchronous queue
// Register-based first-in first-out buffer with full and empty flags.
// ----------------------------------------------------------------------------
module tfcs_fifo #(
	parameter int W     = 33,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  data_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = data_q[rd_ptr_q];

	// Pointer and occupancy tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> src/tfcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front part
// Accepts command transactions, decodes load pixels into canonical RGBA and
// hands classified entries to the queue in front of the back part.
// ----------------------------------------------------------------------------
module tfcs_front (
	input  logic                  push,
	input  tfcs_pkg::cmd_item_t   command_item,
	input  logic [3:0]            src_fmt,
	input  logic                  mid_full,
	output logic                  full,
	output logic                  mid_push,
	output tfcs_pkg::mid_entry_t  mid_entry
);
	// The front stalls only when the queue to the back part is full.
	assign full     = mid_full;
	assign mid_push = push && !mid_full;

	// Classify the command and decode the pixel of a load.
	always_comb begin
		mid_entry.emit = (command_item.command == tfcs_pkg::CMD_EMIT);
		mid_entry.word = tfcs_pkg::decode(command_item.source_pixel, src_fmt);
	end

endmodule

>>> src/tfcs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider producing one quotient bit per cycle for a 9-bit divisor.
// ----------------------------------------------------------------------------
module tfcs_div #(
	parameter int NW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [8:0]    den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [8:0]    den_q;
	logic [8:0]    rem_q;
	logic [KW-1:0] cnt_q;
	logic          busy_q;
	logic [9:0]    rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});
	assign done   = !busy_q;
	assign quo    = num_q;

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= KW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == KW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: the dividend register shifts out while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 9'(rem_sh - {1'b0, den_q}) : rem_sh[8:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

endmodule

>>> src/tfcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back part
// Carries out queued loads and emits: owns the frame store, the load index,
// the destination counters and the nearest-neighbor source lookup.
// ----------------------------------------------------------------------------
module tfcs_back #(
	parameter int MAX_DIM = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tfcs_pkg::cfg_t        cfg,
	input  logic                  mid_empty,
	input  tfcs_pkg::mid_entry_t  mid_entry,
	output logic                  mid_pop,
	input  logic                  out_full,
	output logic                  out_push,
	output tfcs_pkg::res_item_t   out_item
);
	localparam int CW    = $clog2(MAX_DIM);
	localparam int AW    = $clog2(MAX_DIM * MAX_DIM);
	localparam int NW    = CW + 9;
	localparam int CMPW  = (AW > 18) ? AW : 18;
	localparam int SW    = (CW > 9) ? CW : 9;
	localparam int DEPTH = MAX_DIM * MAX_DIM;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_LMUL  = 10'b0000000010,
		S_LWR   = 10'b0000000100,
		S_EMUL  = 10'b0000001000,
		S_DGO   = 10'b0000010000,
		S_DWAIT = 10'b0000100000,
		S_SAT   = 10'b0001000000,
		S_ADDR  = 10'b0010000000,
		S_READ  = 10'b0100000000,
		S_ENC   = 10'b1000000000
	} state_t;

	function automatic logic [8:0] eff(input logic [8:0] v);
		logic [8:0] r;
		if (v == 9'd0) begin
			r = 9'd1;
		end else if (32'(v) > MAX_DIM) begin
			r = 9'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

	state_t               state_q;
	logic [AW-1:0]        load_idx_q;
	logic [CW-1:0]        col_q;
	logic [CW-1:0]        row_q;
	logic [31:0]          word_q;
	logic [17:0]          prod_q;
	logic [NW-1:0]        numx_q;
	logic [NW-1:0]        numy_q;
	logic [8:0]           sx_q;
	logic [8:0]           sy_q;
	logic [AW-1:0]        addr_q;
	logic [31:0]          rdata_q;
	logic [31:0]          mem [DEPTH];
	logic [8:0]           sw;
	logic [8:0]           sh;
	logic [8:0]           dw;
	logic [8:0]           dh;
	logic                 div_start;
	logic                 divx_done;
	logic                 divy_done;
	logic [NW-1:0]        qx;
	logic [NW-1:0]        qy;
	logic                 row_end;
	logic                 frame_end;
	logic                 mem_we;

	assign sw = eff(cfg.src_w);
	assign sh = eff(cfg.src_h);
	assign dw = eff(cfg.dst_w);
	assign dh = eff(cfg.dst_h);

	// Handshakes with the two queues.
	assign mid_pop   = (state_q == S_IDLE) && !mid_empty;
	assign out_push  = (state_q == S_ENC) && !out_full;
	assign div_start = (state_q == S_DGO);
	assign mem_we    = (state_q == S_LWR);

	// End-of-row and end-of-frame flags for the current destination pixel.
	assign row_end   = (SW'(col_q) >= SW'(dw - 9'd1));
	assign frame_end = row_end && (SW'(row_q) >= SW'(dh - 9'd1));

	always_comb begin
		out_item.dest_pixel = tfcs_pkg::encode(rdata_q, cfg.dst_fmt);
		out_item.row_end    = row_end;
		out_item.frame_end  = frame_end;
	end

	// Source column and row quotients.
	tfcs_div #(.NW(NW)) u_divx (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (numx_q),
		.den    (dw),
		.done   (divx_done),
		.quo    (qx)
	);

	tfcs_div #(.NW(NW)) u_divy (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (numy_q),
		.den    (dh),
		.done   (divy_done),
		.quo    (qy)
	);

	// Sequencer and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			load_idx_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (!mid_empty) begin
						state_q <= mid_entry.emit ? S_EMUL : S_LMUL;
					end
				end
				S_LMUL:  state_q <= S_LWR;
				S_LWR: begin
					if (CMPW'(load_idx_q) >= CMPW'(prod_q - 18'd1)) begin
						load_idx_q <= '0;
					end else begin
						load_idx_q <= load_idx_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_EMUL:  state_q <= S_DGO;
				S_DGO:   state_q <= S_DWAIT;
				S_DWAIT: begin
					if (divx_done && divy_done) begin
						state_q <= S_SAT;
					end
				end
				S_SAT:   state_q <= S_ADDR;
				S_ADDR:  state_q <= S_READ;
				S_READ:  state_q <= S_ENC;
				S_ENC: begin
					if (!out_full) begin
						if (row_end) begin
							col_q <= '0;
							row_q <= frame_end ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (mid_pop) begin
			word_q <= mid_entry.word;
		end
		if (state_q == S_LMUL) begin
			prod_q <= 18'(sw * sh);
		end
		if (state_q == S_EMUL) begin
			numx_q <= NW'(NW'(col_q) * NW'(sw));
			numy_q <= NW'(NW'(row_q) * NW'(sh));
		end
		if (state_q == S_SAT) begin
			sx_q <= (qx > NW'(sw - 9'd1)) ? sw - 9'd1 : qx[8:0];
			sy_q <= (qy > NW'(sh - 9'd1)) ? sh - 9'd1 : qy[8:0];
		end
		if (state_q == S_ADDR) begin
			addr_q <= AW'(18'(sy_q * sw) + 18'(sx_q));
		end
	end

	// Frame store: one write port for loads, one registered read for emits.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[load_idx_q] <= word_q;
		end
		rdata_q <= mem[addr_q];
	end

endmodule

>>> src/tfcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Concurrent checks on the top-level ports of the format convert and scale
// block, attached by a bind statement.
// ----------------------------------------------------------------------------
module tfcs_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                psel,
	input logic                penable,
	input logic                pwrite,
	input logic [4:0]          paddr,
	input logic [31:0]         pwdata,
	input logic [31:0]         prdata,
	input logic                empty,
	input logic                pop,
	input tfcs_pkg::res_item_t result_item
);
	// The last pixel of a frame is always the last pixel of its row.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && result_item.frame_end |-> result_item.row_end)
		else $error("frame end without row end");

	// A waiting result transaction is not withdrawn.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result withdrawn before pop");

	// A waiting result transaction holds its value.
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(result_item))
		else $error("result changed while stalled");

	// A destination format write reads back on the next access.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == {tfcs_pkg::REG_DST_FMT, 2'b00} ##1
		psel && penable && !pwrite && paddr == {tfcs_pkg::REG_DST_FMT, 2'b00}
		|-> prdata[3:0] == $past(pwdata[3:0]))
		else $error("destination format read-back mismatch");

endmodule

bind texture_format_convert_scale tfcs_checker u_tfcs_checker (.*);
